### hw/rtl/smalu_pkg.sv
// Shared types, operation codes and widths for the sign-magnitude ALU.
`default_nettype none

package smalu_pkg;

   // Magnitude width and derived sizes
   localparam int MagWidth   = 32;
   localparam int ShiftBits  = $clog2(MagWidth);
   localparam int OpWidth    = 4;

   // Shift amounts at or above this limit clear the magnitude
   localparam logic [MagWidth-1:0] MagLimit = MagWidth'(MagWidth);

   // Operation codes
   localparam logic [OpWidth-1:0] OpAdd  = 4'd0;
   localparam logic [OpWidth-1:0] OpSub  = 4'd1;
   localparam logic [OpWidth-1:0] OpMul  = 4'd2;
   localparam logic [OpWidth-1:0] OpAnd  = 4'd3;
   localparam logic [OpWidth-1:0] OpOr   = 4'd4;
   localparam logic [OpWidth-1:0] OpXor  = 4'd5;
   localparam logic [OpWidth-1:0] OpShl  = 4'd6;
   localparam logic [OpWidth-1:0] OpShr  = 4'd7;
   localparam logic [OpWidth-1:0] OpNot  = 4'd8;
   localparam logic [OpWidth-1:0] OpNeg  = 4'd9;
   localparam logic [OpWidth-1:0] OpPass = 4'd10;
   localparam logic [OpWidth-1:0] OpInc  = 4'd11;
   localparam logic [OpWidth-1:0] OpDec  = 4'd12;
   localparam logic [OpWidth-1:0] OpCmp  = 4'd13;

   // One request item
   typedef struct packed {
      logic [OpWidth-1:0]  op;
      logic                a_sign;
      logic [MagWidth-1:0] a_mag;
      logic                b_sign;
      logic [MagWidth-1:0] b_mag;
   } req_type;

   // One result item
   typedef struct packed {
      logic                result_sign;
      logic [MagWidth-1:0] result_mag;
      logic                overflow;
      logic                less;
      logic                equal;
      logic                greater;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/sign_magnitude_alu.sv
// Top level: input register, datapath and result register of the sign-magnitude ALU.
//
//   channel   ports                        direction  flow
//   request   start, busy, req_item        in         taken when start and not busy
//   result    rsp_strobe, rsp_item         out        one cycle per item, no back-pressure
//
// One item per clock; a taken item passes the input register, the datapath and then the
// result register before its result appears.
// busy is always low: the multiplier and adders sit in one register stage.
// Synchronous active-high reset clears the strobes; payload is not reset.
// The receiver cannot stall, so nothing ever holds in the pipe.
`default_nettype none

module sign_magnitude_alu (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  smalu_pkg::req_type  req_item,
   output logic                rsp_strobe,
   output smalu_pkg::rsp_type  rsp_item
);

   logic               req_valid_ff, req_valid_in;
   smalu_pkg::req_type req_ff;
   smalu_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   assign busy         = 1'b0;
   assign req_valid_in = start & ~busy;

   // Capture the item
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (req_valid_in) begin
         req_ff <= req_item;
      end
   end

   smalu_core u_core (
      .req (req_ff),
      .rsp (rsp_in)
   );

   // Register the result and its strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/smalu_core.sv
// Combinational datapath: computes one result item from one request item.
`default_nettype none

module smalu_core (
   input  smalu_pkg::req_type req,
   output smalu_pkg::rsp_type rsp
);

   localparam int W = smalu_pkg::MagWidth;

   logic [smalu_pkg::OpWidth-1:0] op;
   logic          as, bs;
   logic [W-1:0]  am, bm;

   // adder operands
   logic          add_bs;
   logic [W-1:0]  add_bm;
   logic [W:0]    add_sum;
   logic [W-1:0]  diff_ab, diff_ba;
   logic          a_ge_b;
   logic          add_rs, add_ov;
   logic [W-1:0]  add_rm;

   logic [2*W-1:0] prod;
   logic [2*W-1:0] shl_wide;
   logic           shift_big;

   // compare
   logic          a_zero, b_zero, as_n, bs_n;
   logic          a_gt_mag;
   logic          lt, eq, gt;

   logic          rs, ov;
   logic [W-1:0]  rm;

   assign op = req.op;
   assign as = req.a_sign;
   assign am = req.a_mag;
   assign bs = req.b_sign;
   assign bm = req.b_mag;

   // Pick the second operand of the shared signed adder
   always_comb begin
      unique case (op)
         smalu_pkg::OpSub: begin
            add_bs = ~bs;
            add_bm = bm;
         end
         smalu_pkg::OpInc: begin
            add_bs = 1'b0;
            add_bm = W'(1);
         end
         smalu_pkg::OpDec: begin
            add_bs = 1'b1;
            add_bm = W'(1);
         end
         default: begin
            add_bs = bs;
            add_bm = bm;
         end
      endcase
   end

   // Signed add on magnitudes: sum on like signs, larger minus smaller otherwise
   assign add_sum = {1'b0, am} + {1'b0, add_bm};
   assign diff_ab = am - add_bm;
   assign diff_ba = add_bm - am;
   assign a_ge_b  = (am >= add_bm);

   always_comb begin
      if (as == add_bs) begin
         add_rs = as;
         add_rm = add_sum[W-1:0];
         add_ov = add_sum[W];
      end else if (a_ge_b) begin
         add_rs = as;
         add_rm = diff_ab;
         add_ov = 1'b0;
      end else begin
         add_rs = add_bs;
         add_rm = diff_ba;
         add_ov = 1'b0;
      end
   end

   // Multiply and left shift in double width; high half flags overflow
   assign prod      = {{W{1'b0}}, am} * {{W{1'b0}}, bm};
   assign shift_big = (bm >= smalu_pkg::MagLimit);
   assign shl_wide  = {{W{1'b0}}, am} << bm[smalu_pkg::ShiftBits-1:0];

   // Compare with minus zero folded to plus zero
   assign a_zero   = (am == '0);
   assign b_zero   = (bm == '0);
   assign as_n     = as & ~a_zero;
   assign bs_n     = bs & ~b_zero;
   assign a_gt_mag = (am > bm);

   always_comb begin
      lt = 1'b0;
      eq = 1'b0;
      gt = 1'b0;
      if (as_n != bs_n) begin
         lt = as_n;
         gt = ~as_n;
      end else if (am == bm) begin
         eq = 1'b1;
      end else if (!as_n) begin
         gt = a_gt_mag;
         lt = ~a_gt_mag;
      end else begin
         lt = a_gt_mag;
         gt = ~a_gt_mag;
      end
   end

   // Select the result by operation
   always_comb begin
      rs = 1'b0;
      rm = '0;
      ov = 1'b0;
      unique case (op)
         smalu_pkg::OpAdd, smalu_pkg::OpSub, smalu_pkg::OpInc, smalu_pkg::OpDec: begin
            rs = add_rs;
            rm = add_rm;
            ov = add_ov;
         end
         smalu_pkg::OpMul: begin
            rs = as ^ bs;
            rm = prod[W-1:0];
            ov = |prod[2*W-1:W];
         end
         smalu_pkg::OpAnd: begin
            rs = as & bs;
            rm = am & bm;
         end
         smalu_pkg::OpOr: begin
            rs = as | bs;
            rm = am | bm;
         end
         smalu_pkg::OpXor: begin
            rs = as ^ bs;
            rm = am ^ bm;
         end
         smalu_pkg::OpShl: begin
            rs = as;
            if (shift_big) begin
               rm = '0;
               ov = ~a_zero;
            end else begin
               rm = shl_wide[W-1:0];
               ov = |shl_wide[2*W-1:W];
            end
         end
         smalu_pkg::OpShr: begin
            rs = as;
            rm = shift_big ? '0 : (am >> bm[smalu_pkg::ShiftBits-1:0]);
         end
         smalu_pkg::OpNot: begin
            rs = ~as;
            rm = ~am;
         end
         smalu_pkg::OpNeg: begin
            rs = ~as;
            rm = am;
         end
         smalu_pkg::OpPass: begin
            rs = as;
            rm = am;
         end
         smalu_pkg::OpCmp: begin
            rs = 1'b0;
         end
         default: begin
            rs = 1'b0;
         end
      endcase
   end

   // Zero magnitude always reads as plus zero; flags only on compare
   always_comb begin
      rsp.result_sign = rs & (rm != '0);
      rsp.result_mag  = rm;
      rsp.overflow    = ov;
      rsp.less        = (op == smalu_pkg::OpCmp) & lt;
      rsp.equal       = (op == smalu_pkg::OpCmp) & eq;
      rsp.greater     = (op == smalu_pkg::OpCmp) & gt;
   end

endmodule

`default_nettype wire

### hw/rtl/smalu_checker.sv
// Port-level assertions for the sign-magnitude ALU, bound to the top level.
`default_nettype none

module smalu_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 start,
   input wire                 busy,
   input smalu_pkg::req_type  req_item,
   input wire                 rsp_strobe,
   input smalu_pkg::rsp_type  rsp_item
);

   // Every taken item yields a result through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("taken item produced no result");

   // No result without an item taken ahead of it through the input and result registers
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without a taken item");

   // Compare flags never overlap
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot0({rsp_item.less, rsp_item.equal, rsp_item.greater}))
      else $error("compare flags overlap");

   // Zero magnitude carries plus sign
   a_plus_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.result_mag == '0) |-> !rsp_item.result_sign)
      else $error("minus zero on result");

   // A compare result carries no magnitude, sign or overflow
   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.less || rsp_item.equal || rsp_item.greater))
         |-> (rsp_item.result_mag == '0 && !rsp_item.overflow))
      else $error("compare result has arithmetic fields");

endmodule

bind sign_magnitude_alu smalu_checker u_smalu_checker (.*);

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the sign-magnitude ALU: queued items, clocked driver and monitor.
`timescale 1ns / 1ps

module tb_top;
   import smalu_pkg::*;

   // Op codes the package leaves unnamed; the ALU must return all-zero results
   localparam logic [OpWidth-1:0] OpSpare0 = 4'd14;
   localparam logic [OpWidth-1:0] OpSpare1 = 4'd15;

   localparam int TotalItems   = 1150;
   localparam int PhaseTwoAt   = 400;
   localparam int PhaseThreeAt = 780;
   localparam int StallLimit   = 2000;
   localparam int ReportLimit  = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   req_type pending_q[$];
   rsp_type expected_q[$];
   int      directed_count = 0;
   int      items_sent = 0;
   int      results_seen = 0;
   int      stall_cycles = 0;
   int      fail_count = 0;

   sign_magnitude_alu u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Signed add of two sign-magnitude values; overflow on carry out of the magnitude
   function automatic rsp_type signed_sum(logic as, logic [MagWidth-1:0] am,
                                          logic bs, logic [MagWidth-1:0] bm);
      rsp_type        r;
      logic [MagWidth:0] sum;
      r = '0;
      if (as == bs) begin
         sum = {1'b0, am} + {1'b0, bm};
         r.result_sign = as;
         r.result_mag  = sum[MagWidth-1:0];
         r.overflow    = sum[MagWidth];
      end else if (am >= bm) begin
         r.result_sign = as;
         r.result_mag  = am - bm;
      end else begin
         r.result_sign = bs;
         r.result_mag  = bm - am;
      end
      return r;
   endfunction

   // Expected ALU result for one item
   function automatic rsp_type alu_result(req_type q);
      rsp_type                 r;
      logic [2*MagWidth-1:0]   wide;
      logic                    as_n;
      logic                    bs_n;
      r = '0;
      case (q.op)
         OpAdd: r = signed_sum(q.a_sign, q.a_mag, q.b_sign, q.b_mag);
         OpSub: r = signed_sum(q.a_sign, q.a_mag, ~q.b_sign, q.b_mag);
         OpMul: begin
            wide = {{MagWidth{1'b0}}, q.a_mag} * {{MagWidth{1'b0}}, q.b_mag};
            r.result_sign = q.a_sign ^ q.b_sign;
            r.result_mag  = wide[MagWidth-1:0];
            r.overflow    = |wide[2*MagWidth-1:MagWidth];
         end
         OpAnd: begin
            r.result_sign = q.a_sign & q.b_sign;
            r.result_mag  = q.a_mag & q.b_mag;
         end
         OpOr: begin
            r.result_sign = q.a_sign | q.b_sign;
            r.result_mag  = q.a_mag | q.b_mag;
         end
         OpXor: begin
            r.result_sign = q.a_sign ^ q.b_sign;
            r.result_mag  = q.a_mag ^ q.b_mag;
         end
         OpShl: begin
            r.result_sign = q.a_sign;
            if (q.b_mag >= MagWidth) begin
               r.overflow = (q.a_mag != '0);
            end else begin
               wide = {{MagWidth{1'b0}}, q.a_mag} << q.b_mag;
               r.result_mag = wide[MagWidth-1:0];
               r.overflow   = |wide[2*MagWidth-1:MagWidth];
            end
         end
         OpShr: begin
            r.result_sign = q.a_sign;
            if (q.b_mag < MagWidth) r.result_mag = q.a_mag >> q.b_mag;
         end
         OpNot: begin
            r.result_sign = ~q.a_sign;
            r.result_mag  = ~q.a_mag;
         end
         OpNeg: begin
            r.result_sign = ~q.a_sign;
            r.result_mag  = q.a_mag;
         end
         OpPass: begin
            r.result_sign = q.a_sign;
            r.result_mag  = q.a_mag;
         end
         OpInc: r = signed_sum(q.a_sign, q.a_mag, 1'b0, 1);
         OpDec: r = signed_sum(q.a_sign, q.a_mag, 1'b1, 1);
         OpCmp: begin
            // treat minus zero as plus zero before ordering
            as_n = (q.a_mag == '0) ? 1'b0 : q.a_sign;
            bs_n = (q.b_mag == '0) ? 1'b0 : q.b_sign;
            if (as_n != bs_n) begin
               r.less    = as_n;
               r.greater = ~as_n;
            end else if (q.a_mag == q.b_mag) begin
               r.equal = 1'b1;
            end else begin
               r.greater = (q.a_mag > q.b_mag) ^ as_n;
               r.less    = ~r.greater;
            end
         end
         default: r = '0;
      endcase
      if (r.result_mag == '0) r.result_sign = 1'b0;
      return r;
   endfunction

   // Random magnitude weighted toward the edges of the range
   function automatic logic [MagWidth-1:0] pick_mag();
      logic [MagWidth-1:0] m;
      m = $urandom;
      case ($urandom_range(0, 7))
         0: m = '0;
         1: m = '1;
         2: m = 1;
         3: m = $urandom_range(0, 15);
         4: m[MagWidth-1] = 1'b1;
         5: m = '1 - $urandom_range(0, 15);
         default: ;
      endcase
      return m;
   endfunction

   task automatic queue_op(input logic [OpWidth-1:0] op, input logic as,
                           input logic [MagWidth-1:0] am, input logic bs,
                           input logic [MagWidth-1:0] bm);
      req_type q;
      q.op     = op;
      q.a_sign = as;
      q.a_mag  = am;
      q.b_sign = bs;
      q.b_mag  = bm;
      pending_q.insert(pending_q.size(), q);
   endtask

   // Stimulus, reset and end of run
   initial begin
      req_type q;
      // directed corners
      queue_op(OpAdd,  1'b0, '1, 1'b0, '1);
      queue_op(OpAdd,  1'b0, 5, 1'b1, 5);
      queue_op(OpAdd,  1'b1, 0, 1'b1, 0);
      queue_op(OpSub,  1'b1, 3, 1'b0, 7);
      queue_op(OpSub,  1'b0, '1, 1'b1, 1);
      queue_op(OpMul,  1'b0, '1, 1'b1, 2);
      queue_op(OpMul,  1'b1, 0, 1'b0, '1);
      queue_op(OpAnd,  1'b1, '1, 1'b1, 32'hA5A5_5A5A);
      queue_op(OpOr,   1'b0, 32'h0F0F_0000, 1'b1, 32'h0000_F0F0);
      queue_op(OpXor,  1'b1, '1, 1'b1, '1);
      queue_op(OpShl,  1'b1, 1, 1'b1, MagWidth - 1);
      queue_op(OpShl,  1'b0, 32'h8000_0001, 1'b0, 1);
      queue_op(OpShl,  1'b0, 7, 1'b0, MagWidth);
      queue_op(OpShr,  1'b1, '1, 1'b0, 0);
      queue_op(OpShr,  1'b0, '1, 1'b1, '1);
      queue_op(OpNot,  1'b0, 0, 1'b0, 0);
      queue_op(OpNot,  1'b1, '1, 1'b1, '1);
      queue_op(OpNeg,  1'b0, 0, 1'b1, 9);
      queue_op(OpPass, 1'b1, 0, 1'b0, 0);
      queue_op(OpInc,  1'b1, 1, 1'b0, 0);
      queue_op(OpInc,  1'b0, '1, 1'b1, '1);
      queue_op(OpDec,  1'b0, 0, 1'b0, 0);
      queue_op(OpDec,  1'b1, '1, 1'b0, 3);
      queue_op(OpCmp,  1'b1, 0, 1'b0, 0);
      queue_op(OpCmp,  1'b1, 5, 1'b1, 9);
      queue_op(OpCmp,  1'b0, 3, 1'b0, 4);
      queue_op(OpSpare0, 1'b1, '1, 1'b1, '1);
      queue_op(OpSpare1, 1'b1, 32'h1234_5678, 1'b0, 5);
      directed_count = pending_q.size();

      // random items over every op code, spare ones included
      while (pending_q.size() < TotalItems) begin
         q.op     = OpWidth'($urandom_range(0, 15));
         q.a_sign = 1'($urandom_range(0, 1));
         q.a_mag  = pick_mag();
         q.b_sign = 1'($urandom_range(0, 1));
         if ((q.op == OpShl || q.op == OpShr) && $urandom_range(0, 3) != 0)
            q.b_mag = $urandom_range(0, MagWidth + 3);
         else
            q.b_mag = pick_mag();
         pending_q.insert(pending_q.size(), q);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("sign_magnitude_alu test passed");
      end else begin
         $display("sign_magnitude_alu test failed");
      end
      $finish;
   end

   // Drive items: hold start until taken, idle at random, drain at phase edges
   always @(posedge clock) begin : drive_proc
      logic took;
      logic hold;
      int   n_next;
      int   idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         took   = start && !busy;
         n_next = items_sent + int'(took);
         if (took) begin
            expected_q.insert(expected_q.size(), alu_result(req_item));
            void'(pending_q.pop_front());
         end
         items_sent <= n_next;
         if (took || !start) begin
            hold = (n_next == directed_count || n_next == PhaseTwoAt ||
                    n_next == PhaseThreeAt) && (n_next != results_seen);
            idle_pct = (n_next < PhaseTwoAt) ? 32 : (n_next < PhaseThreeAt) ? 72 : 0;
            if (pending_q.size() != 0 && !hold && $urandom_range(0, 99) >= idle_pct) begin
               start    <= 1'b1;
               req_item <= pending_q[0];
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Check each result against the oldest expectation
   always @(posedge clock) begin : check_proc
      rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (expected_q.size() == 0) begin
            fail_count++;
            if (fail_count <= ReportLimit)
               $display("%0t: result with none expected: sign %0d mag %h", $realtime,
                        rsp_item.result_sign, rsp_item.result_mag);
         end else begin
            want = expected_q.pop_front();
            if (rsp_item.result_sign !== want.result_sign ||
                rsp_item.result_mag !== want.result_mag ||
                rsp_item.overflow !== want.overflow ||
                rsp_item.less !== want.less ||
                rsp_item.equal !== want.equal ||
                rsp_item.greater !== want.greater) begin
               fail_count++;
               if (fail_count <= ReportLimit)
                  $display({"%0t: mismatch exp s%0d m%h ov%0d lt%0d eq%0d gt%0d,",
                            " got s%0d m%h ov%0d lt%0d eq%0d gt%0d"},
                           $realtime, want.result_sign, want.result_mag, want.overflow,
                           want.less, want.equal, want.greater,
                           rsp_item.result_sign, rsp_item.result_mag, rsp_item.overflow,
                           rsp_item.less, rsp_item.equal, rsp_item.greater);
            end
         end
      end
   end

   // Count cycles with no traffic on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < StallLimit) @(posedge clock);
      $display("sign_magnitude_alu test failed");
      $finish;
   end

endmodule
